>>> rtl/sscp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sscp_pkg;

    // Field and datapath widths
    localparam int COORD_BITS  = 24;
    localparam int DIFF_BITS   = COORD_BITS + 1;
    localparam int PROD_BITS   = 2 * DIFF_BITS;
    localparam int DOT_BITS    = PROD_BITS + 2;
    localparam int HALF_BITS   = DOT_BITS / 2;
    localparam int WIDE_BITS   = 2 * DOT_BITS;
    localparam int PARAM_BITS  = 24;
    localparam int PARAM_W     = PARAM_BITS + 1;
    localparam int PPROD_BITS  = DIFF_BITS + PARAM_W + 1;
    localparam int DIST_BITS   = 50;
    localparam int CFG_BITS    = 16;
    localparam int IN_BITS     = 12 * COORD_BITS;
    localparam int OUT_RAW     = DIST_BITS + 6 * COORD_BITS;
    localparam int OUT_BITS    = ((OUT_RAW + 7) / 8) * 8;

    localparam logic [CFG_BITS-1:0]  LIMIT_RESET = CFG_BITS'(17);
    localparam logic [PARAM_W-1:0]   PARAM_ONE   = PARAM_W'(1) << PARAM_BITS;
    localparam logic [DIST_BITS-1:0] DIST_MAX    = '1;

    // Pipeline depths of the multiplier and divider units
    localparam int WMUL_LAT = 2;
    localparam int RAT_LAT  = PARAM_BITS + 1;

    // Segment geometry carried down the pipe
    typedef struct packed {
        logic [2:0][COORD_BITS-1:0] p1;
        logic [2:0][COORD_BITS-1:0] p2;
        logic [2:0][DIFF_BITS-1:0]  d1;
        logic [2:0][DIFF_BITS-1:0]  d2;
    } geom_t;

    // Dot products and point flags
    typedef struct packed {
        logic [DOT_BITS-1:0] a;
        logic [DOT_BITS-1:0] e;
        logic [DOT_BITS-1:0] b;
        logic [DOT_BITS-1:0] c;
        logic [DOT_BITS-1:0] f;
        logic                deg1;
        logic                deg2;
    } dots_t;

    // Closest points
    typedef struct packed {
        logic [2:0][COORD_BITS-1:0] c1;
        logic [2:0][COORD_BITS-1:0] c2;
    } pts_t;

    // Where s and t come from after the second division
    typedef enum logic [2:0] {
        R_ZERO   = 3'd0,
        R_T_ONLY = 3'd1,
        R_S_ONLY = 3'd2,
        R_NEG    = 3'd3,
        R_OVER   = 3'd4,
        R_MID    = 3'd5
    } route_t;

endpackage

`default_nettype wire

>>> rtl/sscp_wmul.sv
`timescale 1ns / 1ps
`default_nettype none

module sscp_wmul (
    input  wire                                   aclk,
    input  wire                                   en,
    input  wire logic signed [sscp_pkg::DOT_BITS-1:0]  x,
    input  wire logic signed [sscp_pkg::DOT_BITS-1:0]  y,
    output logic signed [sscp_pkg::WIDE_BITS-1:0] p
);

    localparam int DB = sscp_pkg::DOT_BITS;
    localparam int HB = sscp_pkg::HALF_BITS;
    localparam int WB = sscp_pkg::WIDE_BITS;

    logic [DB-1:0]   x_mag, y_mag;
    logic [DB-1:0]   p00_reg, p01_reg, p10_reg, p11_reg;
    logic            neg_reg;
    logic [WB-1:0]   sum_next;
    logic [WB-1:0]   p_reg;

    // Take magnitudes, split into halves
    assign x_mag = x[DB-1] ? DB'(-x) : DB'(x);
    assign y_mag = y[DB-1] ? DB'(-y) : DB'(y);

    // Partial products
    always_ff @(posedge aclk) begin
        if (en) begin
            p00_reg <= x_mag[HB-1:0]  * y_mag[HB-1:0];
            p01_reg <= x_mag[HB-1:0]  * y_mag[DB-1:HB];
            p10_reg <= x_mag[DB-1:HB] * y_mag[HB-1:0];
            p11_reg <= x_mag[DB-1:HB] * y_mag[DB-1:HB];
            neg_reg <= x[DB-1] ^ y[DB-1];
        end
    end

    // Combine and restore sign
    always_comb begin
        sum_next = WB'(p00_reg) + ((WB'(p01_reg) + WB'(p10_reg)) << HB)
                 + (WB'(p11_reg) << (2 * HB));
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg <= neg_reg ? WB'(-sum_next) : sum_next;
        end
    end

    assign p = $signed(p_reg);

endmodule

`default_nettype wire

>>> rtl/sscp_ratio.sv
`timescale 1ns / 1ps
`default_nettype none

module sscp_ratio (
    input  wire                                         aclk,
    input  wire                                         en,
    input  wire logic signed [sscp_pkg::WIDE_BITS-1:0]  num,
    input  wire logic signed [sscp_pkg::WIDE_BITS-1:0]  den,
    output logic [sscp_pkg::PARAM_W-1:0]                quot
);

    localparam int WB = sscp_pkg::WIDE_BITS;
    localparam int PB = sscp_pkg::PARAM_BITS;

    typedef enum logic [1:0] {
        FIX_NONE = 2'd0,
        FIX_ZERO = 2'd1,
        FIX_ONE  = 2'd2
    } fix_t;

    logic [WB-1:0] rem_reg  [0:PB];
    logic [WB-1:0] den_reg  [0:PB];
    logic [PB-1:0] q_reg    [0:PB];
    fix_t          fix_reg  [0:PB];
    logic [WB-1:0] rem_next [1:PB];
    logic [PB-1:0] q_next   [1:PB];
    fix_t          fix_entry;

    // Classify: non-positive operands give zero, num >= den gives one
    always_comb begin
        if (den <= 0 || num <= 0) begin
            fix_entry = FIX_ZERO;
        end else if (num >= den) begin
            fix_entry = FIX_ONE;
        end else begin
            fix_entry = FIX_NONE;
        end
    end

    // One restoring quotient bit per stage
    always_comb begin
        logic [WB-1:0] rem2;
        logic          ge;
        for (int k = 1; k <= PB; k++) begin
            rem2        = {rem_reg[k-1][WB-2:0], 1'b0};
            ge          = (rem2 >= den_reg[k-1]);
            rem_next[k] = ge ? rem2 - den_reg[k-1] : rem2;
            q_next[k]   = {q_reg[k-1][PB-2:0], ge};
        end
    end

    // Advance the stages
    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= WB'(num);
            den_reg[0] <= WB'(den);
            q_reg[0]   <= '0;
            fix_reg[0] <= fix_entry;
            for (int k = 1; k <= PB; k++) begin
                rem_reg[k] <= rem_next[k];
                den_reg[k] <= den_reg[k-1];
                q_reg[k]   <= q_next[k];
                fix_reg[k] <= fix_reg[k-1];
            end
        end
    end

    // Apply the clamp
    always_comb begin
        unique case (fix_reg[PB])
            FIX_ZERO: quot = '0;
            FIX_ONE:  quot = sscp_pkg::PARAM_ONE;
            FIX_NONE: quot = {1'b0, q_reg[PB]};
            default:  quot = '0;
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/segment_segment_closest_points.sv
`timescale 1ns / 1ps
`default_nettype none

// Closest points between two 3D segments, Q12.12 fixed point.
// Input stream s_*: one transaction carries both segments (first start,
// first end, second start, second end, each x/y/z). Output stream m_*:
// one transaction per input with the squared distance (raw Q.24,
// saturating) and the closest point on each segment.
// cfg_wr_en/cfg_wr_data set the squared length at or below which a
// segment counts as a point; write it only while the block is empty.
// Throughput: one transaction per cycle unless the pipe holds. Pipe depth
// is set mostly by the two 24-stage restoring dividers (one quotient bit per
// stage) and the split 52x52 multipliers.
// The output has a register plus a skid stage; when the receiver stalls
// and the skid stage fills, the whole pipe holds and s_tready falls, so
// nothing is lost or repeated. aresetn (synchronous, active low) empties
// the pipe and sets the limit to 17.
module segment_segment_closest_points (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    input  wire                                  cfg_wr_en,
    input  wire [sscp_pkg::CFG_BITS-1:0]         cfg_wr_data,
    input  wire                                  s_tvalid,
    output logic                                 s_tready,
    // first_start_x/y/z, first_end_x/y/z, second_start_x/y/z, second_end_x/y/z
    input  wire [sscp_pkg::IN_BITS-1:0]          s_tdata,
    output logic                                 m_tvalid,
    input  wire                                  m_tready,
    // distance_squared, near_first_x/y/z, near_second_x/y/z, zero pad
    output logic [sscp_pkg::OUT_BITS-1:0]        m_tdata
);

    localparam int CB = sscp_pkg::COORD_BITS;
    localparam int DF = sscp_pkg::DIFF_BITS;
    localparam int PR = sscp_pkg::PROD_BITS;
    localparam int DB = sscp_pkg::DOT_BITS;
    localparam int WB = sscp_pkg::WIDE_BITS;
    localparam int PB = sscp_pkg::PARAM_BITS;
    localparam int PW = sscp_pkg::PARAM_W;
    localparam int PP = sscp_pkg::PPROD_BITS;

    // Stage numbers, counted in register edges after acceptance
    localparam int ST_DOT  = 3;
    localparam int ST_WIDE = ST_DOT + sscp_pkg::WMUL_LAT;
    localparam int ST_SEL1 = ST_WIDE + 1;
    localparam int ST_Q1   = ST_SEL1 + sscp_pkg::RAT_LAT;
    localparam int ST_BQ   = ST_Q1 + sscp_pkg::WMUL_LAT;
    localparam int ST_N    = ST_BQ + 1;
    localparam int ST_SEL2 = ST_N + 1;
    localparam int ST_Q2   = ST_SEL2 + sscp_pkg::RAT_LAT;
    localparam int ST_ST   = ST_Q2 + 1;
    localparam int ST_PP   = ST_ST + 1;
    localparam int ST_PT   = ST_PP + 1;
    localparam int ST_SQ   = ST_PT + 1;
    localparam int ST_DIST = ST_SQ + 1;

    logic [sscp_pkg::CFG_BITS-1:0] limit_reg;
    logic                          en;
    logic [ST_DIST:1]              valid_reg;

    sscp_pkg::geom_t  geom_next;
    logic [DF-1:0]    r_next [3];
    sscp_pkg::geom_t  geom_line [1:ST_PP];
    logic [DF-1:0]    r_reg [3];

    logic signed [PR-1:0] paa_reg [3], pee_reg [3], pbb_reg [3];
    logic signed [PR-1:0] pcc_reg [3], pff_reg [3];
    sscp_pkg::dots_t      dots_next;
    sscp_pkg::dots_t      dots_line [ST_DOT:ST_N];

    logic signed [WB-1:0] ae_w, bb_w, bf_w, ce_w, bq_w;
    logic signed [WB-1:0] num1_next, den1_next, num1_reg, den1_reg;
    logic [PW-1:0]        q1, q2;
    logic [PW-1:0]        q1_line [ST_Q1+1:ST_Q2];

    logic signed [WB-1:0] n_reg, d_reg;
    logic signed [WB-1:0] num2_next, den2_next, num2_reg, den2_reg;
    sscp_pkg::route_t     route_next;
    sscp_pkg::route_t     route_line [ST_SEL2:ST_Q2];

    logic [PW-1:0]        s_next, t_next, s_reg, t_reg;
    logic signed [PP-1:0] pp1_reg [3], pp2_reg [3];
    sscp_pkg::pts_t       pts_next;
    sscp_pkg::pts_t       pts_line [ST_PT:ST_DIST];
    logic [sscp_pkg::DIST_BITS-1:0] sq_next [3], sq_reg [3];
    logic [sscp_pkg::DIST_BITS-1:0] dist_next, dist_reg;

    logic [sscp_pkg::OUT_BITS-1:0]  pipe_data;
    logic                           m_tvalid_reg, skid_valid_reg;
    logic [sscp_pkg::OUT_BITS-1:0]  m_tdata_reg, skid_data_reg;

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= sscp_pkg::LIMIT_RESET;
        end else if (cfg_wr_en) begin
            limit_reg <= cfg_wr_data;
        end
    end

    // Whole pipe advances unless the skid stage is occupied
    assign en       = !skid_valid_reg;
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[ST_DIST-1:1], s_tvalid};
        end
    end

    // Stage 1: unpack, form directions and offset
    always_comb begin
        logic signed [CB-1:0] ps1, pe1, ps2, pe2;
        for (int i = 0; i < 3; i++) begin
            ps1 = $signed(s_tdata[i*CB +: CB]);
            pe1 = $signed(s_tdata[(3+i)*CB +: CB]);
            ps2 = $signed(s_tdata[(6+i)*CB +: CB]);
            pe2 = $signed(s_tdata[(9+i)*CB +: CB]);
            geom_next.p1[i] = ps1;
            geom_next.p2[i] = ps2;
            geom_next.d1[i] = DF'(DF'(pe1) - DF'(ps1));
            geom_next.d2[i] = DF'(DF'(pe2) - DF'(ps2));
            r_next[i]       = DF'(DF'(ps1) - DF'(ps2));
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            geom_line[1] <= geom_next;
            for (int k = 2; k <= ST_PP; k++) begin
                geom_line[k] <= geom_line[k-1];
            end
            for (int i = 0; i < 3; i++) begin
                r_reg[i] <= r_next[i];
            end
        end
    end

    // Stage 2: component products
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                paa_reg[i] <= $signed(geom_line[1].d1[i]) * $signed(geom_line[1].d1[i]);
                pee_reg[i] <= $signed(geom_line[1].d2[i]) * $signed(geom_line[1].d2[i]);
                pbb_reg[i] <= $signed(geom_line[1].d1[i]) * $signed(geom_line[1].d2[i]);
                pcc_reg[i] <= $signed(geom_line[1].d1[i]) * $signed(r_reg[i]);
                pff_reg[i] <= $signed(geom_line[1].d2[i]) * $signed(r_reg[i]);
            end
        end
    end

    // Stage 3: dot products and point tests
    always_comb begin
        dots_next.a = DB'(DB'(paa_reg[0]) + DB'(paa_reg[1]) + DB'(paa_reg[2]));
        dots_next.e = DB'(DB'(pee_reg[0]) + DB'(pee_reg[1]) + DB'(pee_reg[2]));
        dots_next.b = DB'(DB'(pbb_reg[0]) + DB'(pbb_reg[1]) + DB'(pbb_reg[2]));
        dots_next.c = DB'(DB'(pcc_reg[0]) + DB'(pcc_reg[1]) + DB'(pcc_reg[2]));
        dots_next.f = DB'(DB'(pff_reg[0]) + DB'(pff_reg[1]) + DB'(pff_reg[2]));
        dots_next.deg1 = (dots_next.a <= DB'(limit_reg));
        dots_next.deg2 = (dots_next.e <= DB'(limit_reg));
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dots_line[ST_DOT] <= dots_next;
            for (int k = ST_DOT + 1; k <= ST_N; k++) begin
                dots_line[k] <= dots_line[k-1];
            end
        end
    end

    // Stages 4-5: wide products of dots
    sscp_wmul u_mul_ae (.aclk(aclk), .en(en), .x($signed(dots_line[ST_DOT].a)),
                        .y($signed(dots_line[ST_DOT].e)), .p(ae_w));
    sscp_wmul u_mul_bb (.aclk(aclk), .en(en), .x($signed(dots_line[ST_DOT].b)),
                        .y($signed(dots_line[ST_DOT].b)), .p(bb_w));
    sscp_wmul u_mul_bf (.aclk(aclk), .en(en), .x($signed(dots_line[ST_DOT].b)),
                        .y($signed(dots_line[ST_DOT].f)), .p(bf_w));
    sscp_wmul u_mul_ce (.aclk(aclk), .en(en), .x($signed(dots_line[ST_DOT].c)),
                        .y($signed(dots_line[ST_DOT].e)), .p(ce_w));

    // Stage 6: pick the first division
    always_comb begin
        sscp_pkg::dots_t dw;
        dw = dots_line[ST_WIDE];
        if (dw.deg1) begin
            num1_next = WB'($signed(dw.f));
            den1_next = WB'($signed(dw.e));
        end else if (dw.deg2) begin
            num1_next = -WB'($signed(dw.c));
            den1_next = WB'($signed(dw.a));
        end else begin
            num1_next = bf_w - ce_w;
            den1_next = ae_w - bb_w;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            num1_reg <= num1_next;
            den1_reg <= den1_next;
        end
    end

    sscp_ratio u_div1 (.aclk(aclk), .en(en), .num(num1_reg), .den(den1_reg), .quot(q1));

    // Hold the first quotient until s and t are settled
    always_ff @(posedge aclk) begin
        if (en) begin
            q1_line[ST_Q1+1] <= q1;
            for (int k = ST_Q1 + 2; k <= ST_Q2; k++) begin
                q1_line[k] <= q1_line[k-1];
            end
        end
    end

    // b * s for the t test
    sscp_wmul u_mul_bq (.aclk(aclk), .en(en), .x($signed(dots_line[ST_Q1].b)),
                        .y($signed(DB'(q1))), .p(bq_w));

    // Form N = b*s + f*one and D = e*one
    always_ff @(posedge aclk) begin
        if (en) begin
            n_reg <= bq_w + (WB'($signed(dots_line[ST_BQ].f)) <<< PB);
            d_reg <= WB'($signed(dots_line[ST_BQ].e)) <<< PB;
        end
    end

    // Pick the second division and the final routing
    always_comb begin
        sscp_pkg::dots_t dn;
        dn        = dots_line[ST_N];
        num2_next = n_reg;
        den2_next = d_reg;
        priority if (dn.deg1 && dn.deg2) begin
            route_next = sscp_pkg::R_ZERO;
        end else if (dn.deg1) begin
            route_next = sscp_pkg::R_T_ONLY;
        end else if (dn.deg2) begin
            route_next = sscp_pkg::R_S_ONLY;
        end else if (n_reg < 0) begin
            route_next = sscp_pkg::R_NEG;
            num2_next  = -WB'($signed(dn.c));
            den2_next  = WB'($signed(dn.a));
        end else if (d_reg < n_reg) begin
            route_next = sscp_pkg::R_OVER;
            num2_next  = WB'($signed(dn.b)) - WB'($signed(dn.c));
            den2_next  = WB'($signed(dn.a));
        end else begin
            route_next = sscp_pkg::R_MID;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            num2_reg            <= num2_next;
            den2_reg            <= den2_next;
            route_line[ST_SEL2] <= route_next;
            for (int k = ST_SEL2 + 1; k <= ST_Q2; k++) begin
                route_line[k] <= route_line[k-1];
            end
        end
    end

    sscp_ratio u_div2 (.aclk(aclk), .en(en), .num(num2_reg), .den(den2_reg), .quot(q2));

    // Settle s and t
    always_comb begin
        unique case (route_line[ST_Q2])
            sscp_pkg::R_ZERO:   begin s_next = '0;               t_next = '0; end
            sscp_pkg::R_T_ONLY: begin s_next = '0;               t_next = q1_line[ST_Q2]; end
            sscp_pkg::R_S_ONLY: begin s_next = q1_line[ST_Q2];   t_next = '0; end
            sscp_pkg::R_NEG:    begin s_next = q2;               t_next = '0; end
            sscp_pkg::R_OVER:   begin s_next = q2;               t_next = sscp_pkg::PARAM_ONE; end
            sscp_pkg::R_MID:    begin s_next = q1_line[ST_Q2];   t_next = q2; end
            default:            begin s_next = '0;               t_next = '0; end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s_reg <= s_next;
            t_reg <= t_next;
        end
    end

    // Direction times parameter
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                pp1_reg[i] <= PP'($signed(geom_line[ST_ST].d1[i]) * $signed({1'b0, s_reg}));
                pp2_reg[i] <= PP'($signed(geom_line[ST_ST].d2[i]) * $signed({1'b0, t_reg}));
            end
        end
    end

    // Round half up and add the start point
    always_comb begin
        logic signed [PP-1:0] half;
        half = PP'(1) <<< (PB - 1);
        for (int i = 0; i < 3; i++) begin
            pts_next.c1[i] = CB'(PP'($signed(geom_line[ST_PP].p1[i]))
                                 + ((pp1_reg[i] + half) >>> PB));
            pts_next.c2[i] = CB'(PP'($signed(geom_line[ST_PP].p2[i]))
                                 + ((pp2_reg[i] + half) >>> PB));
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pts_line[ST_PT] <= pts_next;
            for (int k = ST_PT + 1; k <= ST_DIST; k++) begin
                pts_line[k] <= pts_line[k-1];
            end
        end
    end

    // Squared coordinate differences
    always_comb begin
        logic signed [DF-1:0] dif;
        logic [DF-1:0]        mag;
        for (int i = 0; i < 3; i++) begin
            dif = DF'($signed(pts_line[ST_PT].c1[i])) - DF'($signed(pts_line[ST_PT].c2[i]));
            mag = dif[DF-1] ? DF'(-dif) : DF'(dif);
            sq_next[i] = mag * mag;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                sq_reg[i] <= sq_next[i];
            end
        end
    end

    // Sum and saturate
    always_comb begin
        logic [sscp_pkg::DIST_BITS+1:0] sum;
        sum = (sscp_pkg::DIST_BITS+2)'(sq_reg[0]) + (sscp_pkg::DIST_BITS+2)'(sq_reg[1])
            + (sscp_pkg::DIST_BITS+2)'(sq_reg[2]);
        if (sum > (sscp_pkg::DIST_BITS+2)'(sscp_pkg::DIST_MAX)) begin
            dist_next = sscp_pkg::DIST_MAX;
        end else begin
            dist_next = sum[sscp_pkg::DIST_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dist_reg <= dist_next;
        end
    end

    assign pipe_data = {(sscp_pkg::OUT_BITS - sscp_pkg::OUT_RAW)'(0),
                        pts_line[ST_DIST].c2[2], pts_line[ST_DIST].c2[1],
                        pts_line[ST_DIST].c2[0], pts_line[ST_DIST].c1[2],
                        pts_line[ST_DIST].c1[1], pts_line[ST_DIST].c1[0], dist_reg};

    // Output register with skid stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg   <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!m_tvalid_reg || m_tready) begin
            if (skid_valid_reg) begin
                m_tvalid_reg   <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                m_tvalid_reg <= valid_reg[ST_DIST];
            end
        end else if (en && valid_reg[ST_DIST]) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!m_tvalid_reg || m_tready) begin
            m_tdata_reg <= skid_valid_reg ? skid_data_reg : pipe_data;
        end
        if (en) begin
            skid_data_reg <= pipe_data;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

>>> tb/sscp_checker.sv
`timescale 1ns / 1ps

module sscp_checker (
    input  wire                            aclk,
    input  wire                            aresetn,
    input  wire                            cfg_wr_en,
    input  wire [sscp_pkg::CFG_BITS-1:0]   cfg_wr_data,
    input  wire                            s_tvalid,
    input  wire                            s_tready,
    input  wire [sscp_pkg::IN_BITS-1:0]    s_tdata,
    input  wire                            m_tvalid,
    input  wire                            m_tready,
    input  wire [sscp_pkg::OUT_BITS-1:0]   m_tdata,
    output int                             fail_count,
    output int                             awaited
);
    import sscp_pkg::*;

    // Packed so that it lines up with the low bits of m_tdata
    typedef struct packed {
        logic [2:0][COORD_BITS-1:0] n2;
        logic [2:0][COORD_BITS-1:0] n1;
        logic [DIST_BITS-1:0]       dsq;
    } nearest_t;

    localparam longint ONE = longint'(1) << PARAM_BITS;

    nearest_t            nearest_q[$];
    logic [CFG_BITS-1:0] point_limit;

    // Clamp num/den to [0,1] as a fraction of PARAM_BITS bits
    function automatic longint clamp_ratio(logic signed [159:0] num, logic signed [159:0] den);
        logic signed [159:0] q;
        if (den <= 0 || num <= 0) return 0;
        if (num >= den) return ONE;
        q = (num <<< PARAM_BITS) / den;
        return longint'(q);
    endfunction

    function automatic longint lerp(longint start, longint dir, longint prm);
        return start + ((dir * prm + (ONE >>> 1)) >>> PARAM_BITS);
    endfunction

    function automatic nearest_t closest(logic [IN_BITS-1:0] seg, logic [CFG_BITS-1:0] lim);
        logic signed [COORD_BITS-1:0] v;
        longint p1[3], p2[3], d1[3], d2[3], r[3];
        longint a, e, b, c, f, s, t, df, mag, k1, k2;
        logic signed [159:0] den, nn, dd;
        logic [63:0] sum;
        logic sat;
        nearest_t res;
        a = 0; e = 0; b = 0; c = 0; f = 0; s = 0; t = 0;
        for (int i = 0; i < 3; i++) begin
            v = seg[i*COORD_BITS +: COORD_BITS];        p1[i] = v;
            v = seg[(3+i)*COORD_BITS +: COORD_BITS];    d1[i] = longint'(v) - p1[i];
            v = seg[(6+i)*COORD_BITS +: COORD_BITS];    p2[i] = v;
            v = seg[(9+i)*COORD_BITS +: COORD_BITS];    d2[i] = longint'(v) - p2[i];
            r[i] = p1[i] - p2[i];
        end
        for (int i = 0; i < 3; i++) begin
            a += d1[i] * d1[i];
            e += d2[i] * d2[i];
            b += d1[i] * d2[i];
            c += d1[i] * r[i];
            f += d2[i] * r[i];
        end
        if (a <= lim && e <= lim) begin
            s = 0; t = 0;
        end else if (a <= lim) begin
            t = clamp_ratio(f, e);
        end else if (e <= lim) begin
            s = clamp_ratio(-c, a);
        end else begin
            // Parallel segments keep s at zero
            den = (160'(signed'(a)) * e) - (160'(signed'(b)) * b);
            if (den != 0)
                s = clamp_ratio((160'(signed'(b)) * f) - (160'(signed'(c)) * e), den);
            nn = (160'(signed'(b)) * s) + (160'(signed'(f)) * ONE);
            dd = 160'(signed'(e)) * ONE;
            if (nn < 0) begin
                t = 0; s = clamp_ratio(-c, a);
            end else if (nn > dd) begin
                t = ONE; s = clamp_ratio(b - c, a);
            end else begin
                t = clamp_ratio(nn, dd);
            end
        end
        sum = 0; sat = 1'b0;
        for (int i = 0; i < 3; i++) begin
            k1 = lerp(p1[i], d1[i], s);
            k2 = lerp(p2[i], d2[i], t);
            res.n1[i] = k1[COORD_BITS-1:0];
            res.n2[i] = k2[COORD_BITS-1:0];
            df = k1 - k2;
            mag = df < 0 ? -df : df;
            if (mag >= (longint'(1) << 25)) sat = 1'b1;
            else sum += mag * mag;
        end
        res.dsq = (sat || sum > DIST_MAX) ? DIST_MAX : sum[DIST_BITS-1:0];
        return res;
    endfunction

    initial fail_count = 0;
    assign awaited = nearest_q.size();

    // Track the limit, predict on input, compare on output
    always @(posedge aclk) begin
        nearest_t want, got;
        if (!aresetn) begin
            point_limit = LIMIT_RESET;
            nearest_q.delete();
        end else begin
            if (cfg_wr_en) point_limit = cfg_wr_data;
            if (s_tvalid && s_tready) nearest_q.push_back(closest(s_tdata, point_limit));
            if (m_tvalid && m_tready) begin
                got = m_tdata[OUT_RAW-1:0];
                if (nearest_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) $display("unexpected result %h", got);
                end else begin
                    want = nearest_q.pop_front();
                    if (want.dsq !== got.dsq || want.n1 !== got.n1 || want.n2 !== got.n2) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"mismatch dsq exp %h got %h  p1 exp %h got %h",
                                      "  p2 exp %h got %h"},
                                     want.dsq, got.dsq, want.n1, got.n1, want.n2, got.n2);
                    end
                end
            end
        end
    end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import sscp_pkg::*;

    localparam int MAXC = (1 << (COORD_BITS - 1)) - 1;
    localparam int MINC = -(1 << (COORD_BITS - 1));

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                cfg_wr_en = 1'b0;
    logic [CFG_BITS-1:0] cfg_wr_data = '0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [IN_BITS-1:0]  s_tdata = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [OUT_BITS-1:0] m_tdata;
    int                  fail_count, awaited;
    bit                  long_hold = 1'b0;

    always #6 aclk = ~aclk;

    segment_segment_closest_points dut (.*);

    sscp_checker chk (.*);

    // Receiver: random back-pressure, plus one long hold-off on request
    initial begin
        int w;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (long_hold) begin
                long_hold = 1'b0;
                m_tready <= 1'b0;
                repeat (300) @(negedge aclk);
            end
            w = $urandom_range(0, 5);
            if ($urandom_range(0, 3) == 0) w = 0;
            if (w > 0) begin
                m_tready <= 1'b0;
                repeat (w) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance
    task automatic send_pair(int c[12], bit no_gap = 0);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        for (int i = 0; i < 12; i++) s_tdata[i*COORD_BITS +: COORD_BITS] <= c[i][COORD_BITS-1:0];
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic drain_and_set(logic [CFG_BITS-1:0] lim);
        s_tvalid <= 1'b0;
        while (awaited != 0) @(negedge aclk);
        repeat (80) @(negedge aclk);
        cfg_wr_data <= lim;
        cfg_wr_en <= 1'b1;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic int rnd_full();
        return int'($urandom) >>> 8;
    endfunction

    function automatic int near_val(int base, int span);
        longint v;
        v = longint'(base) + $urandom_range(0, 2 * span) - span;
        if (v > MAXC) v = MAXC;
        if (v < MINC) v = MINC;
        return int'(v);
    endfunction

    // Random pair of a chosen flavour
    task automatic rand_pair(output int c[12]);
        int kind, k, span;
        kind = $urandom_range(0, 9);
        span = (kind < 5) ? (1 << $urandom_range(2, 16)) : 4096;
        for (int i = 0; i < 12; i++)
            c[i] = (kind == 0) ? rnd_full() : near_val(0, span);
        case (kind)
            5: for (int i = 0; i < 3; i++) c[3+i] = near_val(c[i], 2);      // first ~point
            6: for (int i = 0; i < 3; i++) c[9+i] = near_val(c[6+i], 2);    // second ~point
            7: begin
                // Parallel: second direction a multiple of the first
                k = $urandom_range(0, 4) - 2;
                for (int i = 0; i < 3; i++) begin
                    c[3+i] = near_val(c[i], 500);
                    c[9+i] = c[6+i] + k * (c[3+i] - c[i]);
                end
            end
            8: for (int i = 0; i < 3; i++) begin
                // Crossing region, pushes t outside [0,1] often
                c[6+i] = near_val(c[i], 8000);
                c[9+i] = near_val(c[6+i], 300);
            end
            default: ;
        endcase
    endtask

    initial begin
        int c[12];
        int n;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: extremes, points, parallel, far apart
        for (int i = 0; i < 12; i++) c[i] = MAXC;            send_pair(c);
        for (int i = 0; i < 12; i++) c[i] = MINC;            send_pair(c);
        for (int i = 0; i < 12; i++) c[i] = (i < 6) ? MINC : MAXC; send_pair(c);
        for (int i = 0; i < 12; i++) c[i] = (i % 2) ? MINC : MAXC; send_pair(c);
        for (int i = 0; i < 12; i++) c[i] = (i % 6 < 3) ? MINC : MAXC; send_pair(c);
        for (int i = 0; i < 12; i++) c[i] = 0;               send_pair(c);
        c = '{0,0,0, 2,2,2, 100,0,0, 100,1,1};               send_pair(c);
        c = '{0,0,0, 3,3,3, 100,0,0, 104,0,0};               send_pair(c);
        c = '{0,0,0, 1000,0,0, 500,-50,0, 500,50,0};         send_pair(c);
        c = '{0,0,0, 1000,0,0, 0,10,0, 1000,10,0};           send_pair(c);
        c = '{0,0,0, 1000,0,0, 3000,10,0, 2000,10,0};        send_pair(c);
        c = '{0,0,0, 1000,0,0, -500,5,0, 500,5,0};           send_pair(c);
        c = '{0,0,0, 1000,1000,0, 2000,0,5, 3000,-100,5};    send_pair(c);
        c = '{0,0,0, 1000,0,0, 1500,-200,0, 1500,-100,0};    send_pair(c);
        c = '{0,0,0, 100,0,0, -300,0,50, -300,0,40};         send_pair(c);
        c = '{MINC,MINC,MINC, MINC,MINC,MINC, MAXC,MAXC,MAXC, MAXC,MAXC,MAXC}; send_pair(c);
        c = '{MINC,0,0, MAXC,0,0, 0,MINC,MAXC, 0,MAXC,MINC}; send_pair(c);

        // Limit extremes, then mixed settings with random traffic
        drain_and_set(16'd0);
        c = '{0,0,0, 1,0,0, 100,0,0, 100,1,0};               send_pair(c);
        c = '{0,0,0, 0,0,0, 100,0,0, 101,0,0};               send_pair(c);
        drain_and_set(16'hFFFF);
        c = '{0,0,0, 255,0,0, 1000,0,0, 1000,256,0};         send_pair(c);
        c = '{0,0,0, 256,0,0, 1000,0,0, 1000,255,0};         send_pair(c);
        c = '{5,5,5, 5,5,5, -7,9,1, -7,9,1};                 send_pair(c);

        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: drain_and_set(LIMIT_RESET);
                1: drain_and_set(16'd0);
                2: drain_and_set(16'hFFFF);
                default: drain_and_set(CFG_BITS'($urandom));
            endcase
            n = 0;
            repeat (110) begin
                rand_pair(c);
                if (ph == 1 && n == 20) long_hold = 1'b1;
                // Back-to-back offers while the receiver holds off
                send_pair(c, ph == 1 && n >= 20 && n < 90);
                n++;
            end
        end

        s_tvalid <= 1'b0;
        while (awaited != 0) @(negedge aclk);
        repeat (100) @(negedge aclk);
        if (fail_count == 0 && awaited == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

    initial begin
        #(12 * 200000);
        $display("tb NOT OK");
        $finish;
    end

endmodule

>>> files.f
rtl/sscp_pkg.sv
rtl/sscp_wmul.sv
rtl/sscp_ratio.sv
rtl/segment_segment_closest_points.sv
tb/sscp_checker.sv
tb/tb.sv
